[rtl/fwhc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fwhc_pkg : shared types and constants of the histogram counter
// Request and result words, configuration set, status codes, divider links.
// ----------------------------------------------------------------------------
package fwhc_pkg;

  // default sizing of the count store
  localparam int DEF_MAX_BINS   = 1024;
  localparam int DEF_COUNT_BITS = 32;

  // fixed top of the overflow bin
  localparam logic signed [31:0] OVERFLOW_TOP = 32'sd250000000;

  // serial divider: one quotient bit per step
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // register file
  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_RANGE_START = 2'd0,
    REG_RANGE_END   = 2'd1,
    REG_BIN_WIDTH   = 2'd2
  } reg_idx_t;

  localparam logic signed [31:0] RST_RANGE_START = 32'sd0;
  localparam logic signed [31:0] RST_RANGE_END   = 32'sd1023;
  localparam logic [30:0]        RST_BIN_WIDTH   = 31'd1;

  // request codes, anything else reads a bin
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BELOW  = 3'd1,
    ST_ABOVE  = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_SAT    = 3'd4,
    ST_BADIDX = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [31:0]  value;
    logic [9:0]          bin_select;
  } req_t;

  typedef struct packed {
    logic [9:0]  bin_index;
    logic [31:0] bin_count;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
    logic [30:0]        bin_width;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/fwhc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fwhc_ram : generic single-port-write, single-port-read memory
// One write and one registered read per cycle, no reset on contents.
// ----------------------------------------------------------------------------
module fwhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/fwhc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fwhc_div : bit-serial restoring divider
// Unsigned 32 by 31 bit division, one quotient bit shifted in per cycle.
// ----------------------------------------------------------------------------
module fwhc_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fwhc_pkg::div_req_t req,
  output fwhc_pkg::div_rsp_t      rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [fwhc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]                  rem_r, rem_nxt;
  logic [31:0]                  quo_r, quo_nxt;
  logic [30:0]                  dsr_r, dsr_nxt;

  logic [31:0] trial;
  logic [31:0] trial_diff;
  logic        fits;

  // one trial subtraction per cycle
  assign trial      = {rem_r[30:0], quo_r[31]};
  assign fits       = trial >= {1'b0, dsr_r};
  assign trial_diff = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = fwhc_pkg::DIV_CNT_W'(fwhc_pkg::DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_diff : trial;
      quo_nxt = {quo_r[30:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == fwhc_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp = '{done: done_r, quotient: quo_r};

endmodule
`default_nettype wire

[rtl/fwhc_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fwhc_regs : configuration registers behind the APB-style port
// Range bounds and bin width, written in the access phase, read back as held.
// ----------------------------------------------------------------------------
module fwhc_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fwhc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output fwhc_pkg::cfg_t                    cfg
);

  fwhc_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        fwhc_pkg::REG_RANGE_START: cfg_nxt.range_start = pwdata;
        fwhc_pkg::REG_RANGE_END:   cfg_nxt.range_end   = pwdata;
        fwhc_pkg::REG_BIN_WIDTH:   cfg_nxt.bin_width   = pwdata[30:0];
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      fwhc_pkg::REG_RANGE_START: prdata = cfg_r.range_start;
      fwhc_pkg::REG_RANGE_END:   prdata = cfg_r.range_end;
      fwhc_pkg::REG_BIN_WIDTH:   prdata = {1'b0, cfg_r.bin_width};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_start <= fwhc_pkg::RST_RANGE_START;
      cfg_r.range_end   <= fwhc_pkg::RST_RANGE_END;
      cfg_r.bin_width   <= fwhc_pkg::RST_BIN_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[rtl/fixed_width_histogram_counter_unit.sv]
`default_nettype none
// Add and remove words wait on the bit-serial divider's 32 steps; reads and values
// below the range or above the overflow top skip it. A new word is taken only
// after the last result has moved to the output register.
// After reset a clearing pass writes zero into every bin, with
// in_ready low throughout; configuration writes are taken during the pass.
// Registers come out of reset as 0, 1023 and 1; writing them keeps the counts.
// ----------------------------------------------------------------------------
// fixed_width_histogram_counter_unit : equal-width histogram counter
// Maps each value to its bin through a serial divider and updates the
// count store; reads return a bin's count with a status.
// ----------------------------------------------------------------------------
module fixed_width_histogram_counter_unit #(
  parameter int MAX_BINS   = fwhc_pkg::DEF_MAX_BINS,
  parameter int COUNT_BITS = fwhc_pkg::DEF_COUNT_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire fwhc_pkg::req_t               in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output fwhc_pkg::res_t                    out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fwhc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASSIFY,
    S_DIVIDE,
    S_LOOKUP,
    S_ACCESS,
    S_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  fwhc_pkg::req_t     req_r, req_nxt;
  fwhc_pkg::res_t     res_r, res_nxt;
  fwhc_pkg::res_t     out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               ovf_r, ovf_nxt;
  logic [32:0]        idx_r, idx_nxt;

  fwhc_pkg::cfg_t     cfg;
  fwhc_pkg::div_req_t div_req;
  fwhc_pkg::div_rsp_t div_rsp;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // classification of the held value
  logic               is_read;
  logic               below;
  logic               in_regular;
  logic               in_overflow;
  logic               inverted;
  logic signed [31:0] span_top;
  logic [32:0]        span;
  logic [31:0]        dividend;
  logic [30:0]        eff_width;
  logic [32:0]        div_idx;
  logic [32:0]        sel_ext;
  logic [63:0]        cnt_wide;
  logic [63:0]        upd_wide;
  logic [COUNT_BITS-1:0] cnt_upd;

  fwhc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fwhc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  fwhc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign is_read = (req_r.req_type != fwhc_pkg::REQ_ADD) &&
                   (req_r.req_type != fwhc_pkg::REQ_REMOVE);

  // range compares and dividend selection
  assign below       = req_r.value < cfg.range_start;
  assign in_regular  = req_r.value <= cfg.range_end;
  assign in_overflow = req_r.value <= fwhc_pkg::OVERFLOW_TOP;
  assign inverted    = cfg.range_end < cfg.range_start;
  assign span_top    = in_regular ? req_r.value : cfg.range_end;
  assign span        = {span_top[31], span_top} - {cfg.range_start[31], cfg.range_start};
  assign dividend    = (!in_regular && inverted) ? 32'd0 : span[31:0];
  assign eff_width   = (cfg.bin_width == '0) ? 31'd1 : cfg.bin_width;

  // overflow bin sits one past the last regular bin
  assign div_idx = {1'b0, div_rsp.quotient} + {32'd0, ovf_r};
  assign sel_ext = 33'(req_r.bin_select);

  // count update
  assign cnt_upd  = (req_r.req_type == fwhc_pkg::REQ_ADD) ? ram_rdata + 1'b1
                                                          : ram_rdata - 1'b1;
  assign cnt_wide = 64'(ram_rdata);
  assign upd_wide = 64'(cnt_upd);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    clr_addr_nxt  = clr_addr_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    in_ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = dividend;
    div_req.divisor  = eff_width;
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = cnt_upd;
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];

    // output slot frees when the word is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // zero the count store one bin per cycle
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_data;
          if ((in_data.req_type != fwhc_pkg::REQ_ADD) &&
              (in_data.req_type != fwhc_pkg::REQ_REMOVE)) begin
            state_nxt = S_LOOKUP;
          end else begin
            state_nxt = S_CLASSIFY;
          end
        end
      end

      // range checks, then hand the offset to the divider
      S_CLASSIFY: begin
        if (below) begin
          res_nxt   = '{bin_index: '0, bin_count: '0, status: fwhc_pkg::ST_BELOW};
          state_nxt = S_FINISH;
        end else if (!in_regular && !in_overflow) begin
          res_nxt   = '{bin_index: '0, bin_count: '0, status: fwhc_pkg::ST_ABOVE};
          state_nxt = S_FINISH;
        end else begin
          div_req.start = 1'b1;
          ovf_nxt       = !in_regular;
          state_nxt     = S_DIVIDE;
        end
      end

      S_DIVIDE: begin
        if (div_rsp.done) begin
          idx_nxt = div_idx;
          if (div_idx >= 33'(MAX_BINS)) begin
            res_nxt   = '{bin_index: '0, bin_count: '0, status: fwhc_pkg::ST_ABOVE};
            state_nxt = S_FINISH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = div_idx[AW-1:0];
            state_nxt = S_ACCESS;
          end
        end
      end

      // read request: check the index and fetch
      S_LOOKUP: begin
        idx_nxt = sel_ext;
        if (sel_ext >= 33'(MAX_BINS)) begin
          res_nxt   = '{bin_index: '0, bin_count: '0, status: fwhc_pkg::ST_BADIDX};
          state_nxt = S_FINISH;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = sel_ext[AW-1:0];
          state_nxt = S_ACCESS;
        end
      end

      // count read back, update where allowed
      S_ACCESS: begin
        res_nxt.bin_index = idx_r[9:0];
        res_nxt.bin_count = cnt_wide[31:0];
        res_nxt.status    = fwhc_pkg::ST_OK;
        if (!is_read) begin
          if ((req_r.req_type == fwhc_pkg::REQ_ADD) && (ram_rdata == '1)) begin
            res_nxt.status = fwhc_pkg::ST_SAT;
          end else if ((req_r.req_type == fwhc_pkg::REQ_REMOVE) && (ram_rdata == '0)) begin
            res_nxt.status = fwhc_pkg::ST_EMPTY;
          end else begin
            ram_we            = 1'b1;
            res_nxt.bin_count = upd_wide[31:0];
          end
        end
        state_nxt = S_FINISH;
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    ovf_r      <= ovf_nxt;
    idx_r      <= idx_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      clr_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_addr_r  <= clr_addr_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while another is in flight");

  // the store is only written by the clearing pass or a count update
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR) || (state_r == S_ACCESS))
    else $error("count store written outside clear or update");

  // an update always changes the stored count
  a_update_changes: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && (state_r == S_ACCESS) |-> ram_wdata != ram_rdata)
    else $error("count update leaves the value unchanged");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIVIDE)
    else $error("divider result with no division pending");

  // a finished result with a free slot is presented next cycle
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) && !out_valid_r |=> out_valid_r)
    else $error("result not moved to the output register");

endmodule
`default_nettype wire

[verif/histogram_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_checker : result checker for the equal-width histogram counter
// Watches the request, result and register ports, keeps its own copy of the
// range registers and the bin counts, predicts the result of every accepted
// request word and compares each result word, field by field, with the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module histogram_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  fwhc_pkg::req_t                in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  fwhc_pkg::res_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [fwhc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output int                            fail_count,
  output int                            outstanding,
  output int                            results_seen,
  output bit   [7:0]                    status_mask
);

  localparam int TALLY_DEPTH = fwhc_pkg::DEF_MAX_BINS;

  // shadow of the range registers
  logic signed [31:0] cfg_start;
  logic signed [31:0] cfg_end;
  logic        [30:0] cfg_width;

  // shadow of the count store
  logic [31:0] bin_tally [0:TALLY_DEPTH-1];

  fwhc_pkg::res_t pending_results [$];
  int             accepted_cnt;
  int             checked_cnt;

  assign outstanding  = accepted_cnt - checked_cnt;
  assign results_seen = checked_cnt;

  // one line per mismatch, and count it
  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // bin lookup and count update for one request word
  function automatic fwhc_pkg::res_t predict_bin_update(fwhc_pkg::req_t w);
    fwhc_pkg::res_t r;
    longint         lo;
    longint         hi;
    longint         v;
    longint         step;
    longint         last_bin;
    longint         bin;
    logic [31:0]    cnt;
    r        = '0;
    r.status = fwhc_pkg::ST_OK;
    // anything but add or remove reads a bin
    if (w.req_type != fwhc_pkg::REQ_ADD && w.req_type != fwhc_pkg::REQ_REMOVE) begin
      if (w.bin_select >= TALLY_DEPTH) begin
        r.status = fwhc_pkg::ST_BADIDX;
      end else begin
        r.bin_index = w.bin_select;
        r.bin_count = bin_tally[w.bin_select];
      end
      return r;
    end
    lo       = cfg_start;
    hi       = cfg_end;
    v        = $signed(w.value);
    step     = (cfg_width == '0) ? 1 : longint'(cfg_width);
    last_bin = (hi >= lo) ? (hi - lo) / step : 0;
    if (v < lo) begin
      r.status = fwhc_pkg::ST_BELOW;
      return r;
    end
    // regular bins, then the overflow bin up to the fixed top
    if (v <= hi) begin
      bin = (v - lo) / step;
      if (bin > last_bin) bin = last_bin;
    end else if (v <= longint'(fwhc_pkg::OVERFLOW_TOP)) begin
      bin = last_bin + 1;
    end else begin
      r.status = fwhc_pkg::ST_ABOVE;
      return r;
    end
    if (bin >= TALLY_DEPTH) begin
      r.status = fwhc_pkg::ST_ABOVE;
      return r;
    end
    cnt         = bin_tally[bin];
    r.bin_index = bin[9:0];
    if (w.req_type == fwhc_pkg::REQ_ADD) begin
      if (cnt == '1) begin
        r.bin_count = cnt;
        r.status    = fwhc_pkg::ST_SAT;
        return r;
      end
      cnt = cnt + 1;
    end else begin
      if (cnt == '0) begin
        r.status = fwhc_pkg::ST_EMPTY;
        return r;
      end
      cnt = cnt - 1;
    end
    bin_tally[bin] = cnt;
    r.bin_count    = cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    fwhc_pkg::res_t want;
    if (!rst_n) begin
      for (int i = 0; i < TALLY_DEPTH; i++) bin_tally[i] = '0;
      cfg_start = fwhc_pkg::RST_RANGE_START;
      cfg_end   = fwhc_pkg::RST_RANGE_END;
      cfg_width = fwhc_pkg::RST_BIN_WIDTH;
      pending_results.delete();
      accepted_cnt <= 0;
      checked_cnt  <= 0;
    end else begin
      // result word against the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending", out_data.bin_index, 0);
        end else begin
          want = pending_results.pop_front();
          checked_cnt <= checked_cnt + 1;
          if (out_data.bin_index !== want.bin_index)
            report_mismatch("bin_index", out_data.bin_index, want.bin_index);
          if (out_data.bin_count !== want.bin_count)
            report_mismatch("bin_count", out_data.bin_count, want.bin_count);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
        if (!$isunknown(out_data.status)) status_mask[out_data.status] = 1'b1;
      end
      // prediction for each accepted request word
      if (in_valid && in_ready) begin
        accepted_cnt <= accepted_cnt + 1;
        pending_results.insert(pending_results.size(), predict_bin_update(in_data));
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fwhc_pkg::REG_RANGE_START: cfg_start = pwdata;
          fwhc_pkg::REG_RANGE_END:   cfg_end   = pwdata;
          fwhc_pkg::REG_BIN_WIDTH:   cfg_width = pwdata[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : testbench of the equal-width histogram counter
// Resets the block, sends a short directed set of request words at the reset
// ranges, then runs random add, remove and read traffic under a series of
// range settings (narrow, full span, zero width, inverted, near the overflow
// top), with random gaps and stalls on both channels. A separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] REQ_READ     = 2'd2;
  localparam logic [1:0] REQ_READ_ALT = 2'd3;
  localparam int         LONG_HOLD    = 400;
  localparam int         DRAIN_TAIL   = 48;
  localparam int         RUN_LIMIT_NS = 1_500_000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  fwhc_pkg::req_t               in_data;
  logic                         out_valid;
  logic                         out_ready;
  fwhc_pkg::res_t               out_data;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [fwhc_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  int                   fail_count;
  int                   outstanding;
  int                   results_seen;
  bit   [7:0]           status_mask;

  // range settings as the stimulus sees them
  longint               cur_start;
  longint               cur_end;
  longint               cur_width;
  logic [31:0]          recent_adds [$];

  int                   src_burst_left;
  int                   sink_burst_left;
  bit                   sink_hold_req;

  always #1 clk = ~clk;

  fixed_width_histogram_counter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  histogram_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .status_mask  (status_mask)
  );

  function automatic fwhc_pkg::req_t make_word(logic [1:0] kind, logic [31:0] val,
                                               logic [9:0] sel);
    fwhc_pkg::req_t w;
    w.req_type   = kind;
    w.value      = val;
    w.bin_select = sel;
    return w;
  endfunction

  // random request word shaped by the current ranges
  function automatic fwhc_pkg::req_t random_word();
    fwhc_pkg::req_t w;
    int unsigned    pick;
    longint         step;
    longint         span;
    longint         last_bin;
    longint         v;
    step         = (cur_width == 0) ? 1 : cur_width;
    span         = cur_end - cur_start;
    last_bin     = (span >= 0) ? span / step : 0;
    w.value      = $urandom;
    w.bin_select = 10'($urandom_range(0, 1023));
    pick         = $urandom_range(0, 99);
    if (pick < 45) w.req_type = fwhc_pkg::REQ_ADD;
    else if (pick < 75) w.req_type = fwhc_pkg::REQ_REMOVE;
    else if (pick < 95) w.req_type = REQ_READ;
    else w.req_type = REQ_READ_ALT;
    // reads mostly aim at bins in use
    if (w.req_type == REQ_READ || w.req_type == REQ_READ_ALT) begin
      if ($urandom_range(0, 9) < 7)
        w.bin_select = 10'($urandom_range(0,
                           32'((last_bin + 1 > 1023) ? 1023 : last_bin + 1)));
      return w;
    end
    // removes mostly take back a recent add
    if (w.req_type == fwhc_pkg::REQ_REMOVE && recent_adds.size() > 0 &&
        $urandom_range(0, 9) < 6) begin
      w.value = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
      return w;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55 && span >= 0) begin
      v = cur_start + longint'({$urandom}) % (span + 1);
    end else if (pick < 70) begin
      case ($urandom_range(0, 7))
        0:       v = cur_start;
        1:       v = cur_start - 1;
        2:       v = cur_end;
        3:       v = cur_end + 1;
        4:       v = fwhc_pkg::OVERFLOW_TOP;
        5:       v = longint'(fwhc_pkg::OVERFLOW_TOP) + 1;
        6:       v = cur_start + step;
        default: v = cur_start + step - 1;
      endcase
    end else if (pick < 85) begin
      v = cur_end + 1 + $urandom_range(0, 2000);
    end else if (pick < 92) begin
      v = cur_start - 1 - $urandom_range(0, 1000);
    end else begin
      v = $urandom;
    end
    w.value = v[31:0];
    if (w.req_type == fwhc_pkg::REQ_ADD) begin
      recent_adds.insert(recent_adds.size(), w.value);
      if (recent_adds.size() > 48) void'(recent_adds.pop_front());
    end
    return w;
  endfunction

  // offer one request word after a random gap, return once accepted
  task automatic send_word(fwhc_pkg::req_t w);
    int unsigned gap;
    if (src_burst_left > 0) begin
      gap = 0;
      src_burst_left--;
    end else begin
      if ($urandom_range(0, 39) == 0) src_burst_left = $urandom_range(20, 40);
      gap = $urandom_range(0, 17);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // setup then access cycle, select left high for a following write
  task automatic reg_write(fwhc_pkg::reg_idx_t r, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_ranges(longint s, longint e, longint wd);
    reg_write(fwhc_pkg::REG_RANGE_START, s[31:0]);
    reg_write(fwhc_pkg::REG_RANGE_END, e[31:0]);
    reg_write(fwhc_pkg::REG_BIN_WIDTH, {1'b0, wd[30:0]});
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    cur_start  = s;
    cur_end    = e;
    cur_width  = wd;
  endtask

  // one range setting with random traffic, optional long stall or pause midway
  task automatic run_phase(longint s, longint e, longint wd, int count, bit with_hold,
                           bit with_pause);
    drain_results();
    program_ranges(s, e, wd);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && with_hold) begin
        sink_hold_req  = 1'b1;
        src_burst_left = 30;
      end
      if (i == count / 2 && with_pause) drain_results();
      send_word(random_word());
    end
  endtask

  // result side: random stalls, bursts and one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sink_burst_left > 0) begin
        stall = 0;
        sink_burst_left--;
      end else begin
        if ($urandom_range(0, 39) == 0) sink_burst_left = $urandom_range(20, 40);
        stall = $urandom_range(0, 17);
      end
      if (sink_hold_req) begin
        stall         = stall + LONG_HOLD;
        sink_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    in_valid  <= 1'b0;
    in_data   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    rst_n     <= 1'b0;
    cur_start  = fwhc_pkg::RST_RANGE_START;
    cur_end    = fwhc_pkg::RST_RANGE_END;
    cur_width  = fwhc_pkg::RST_BIN_WIDTH;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset ranges: edges of the bins, overflow bin past the store, empty bins
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'd0,          10'd0));
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'd1023,       10'd1023));
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'd1024,       10'd0));
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'hFFFF_FFFF,  10'd1023));
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'h8000_0000,  10'd0));
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'h7FFF_FFFF,  10'd1023));
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'd250000000,  10'd0));
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'd250000001,  10'd0));
    send_word(make_word(fwhc_pkg::REQ_REMOVE, 32'd5,          10'd0));
    send_word(make_word(fwhc_pkg::REQ_REMOVE, 32'd0,          10'd0));
    send_word(make_word(fwhc_pkg::REQ_REMOVE, 32'd0,          10'd1023));
    send_word(make_word(REQ_READ,             32'd0,          10'd0));
    send_word(make_word(REQ_READ,             32'hFFFF_FFFF,  10'd1023));
    send_word(make_word(REQ_READ_ALT,         32'd0,          10'd1023));
    send_word(make_word(REQ_READ,             32'hFFFF_FFFF,  10'd512));
    send_word(make_word(fwhc_pkg::REQ_ADD,    32'd512,        10'd512));
    send_word(make_word(REQ_READ_ALT,         32'd0,          10'd512));

    // random traffic over a series of range settings, counts carried across
    run_phase(-100, 100, 10, 250, 1'b1, 1'b0);
    run_phase(-2147483648, 2147483647, 2147483647, 200, 1'b0, 1'b0);
    run_phase(1000, 1500, 0, 250, 1'b0, 1'b1);
    run_phase(200, -5, 7, 200, 1'b0, 1'b0);
    run_phase(0, 300000000, 1, 200, 1'b0, 1'b0);
    run_phase(-2000000000, 2000000000, 4000000, 250, 1'b1, 1'b0);
    run_phase(249999000, 249999500, 1, 200, 1'b0, 1'b0);
    run_phase(-7, 57, 3, 180, 1'b0, 1'b0);
    run_phase(2147483647, 2147483647, 1, 60, 1'b0, 1'b0);
    run_phase(-2147483648, -2147483648, 5, 60, 1'b0, 1'b0);
    drain_results();

    $display("run covered %0d result words under eleven range settings", results_seen);
    $display("including inverted, zero-width and full-span ranges; status codes seen %b",
             status_mask);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
